// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros of the ranger rtl, used by uer_fsm
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UER_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uer: same-cycle check failed");

// next-cycle implication
`define UER_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uer: next-cycle check failed");

`endif

// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// types and constants of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_TRIG_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DIST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DIST = 3'd4;

   localparam logic [7:0] RST_TRIG_WIDTH = 8'd12;
   localparam logic [15:0] RST_ECHO_TIMEOUT = 16'd60000;
   localparam logic [15:0] RST_SCALE = 16'd1124;
   localparam logic [23:0] RST_MIN_DIST = 24'd512;
   localparam logic [23:0] RST_MAX_DIST = 24'd102400;

   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
   localparam logic [32:0] ROUND_HALF = 33'd128;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_RISE = 2'd2,
      PH_MEAS = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NO_RISE = 2'd1,
      ST_TOO_LONG = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] trigger_width_ticks;
      logic [15:0] echo_timeout_ticks;
      logic [15:0] scale_q16;
      logic [23:0] min_distance_q8;
      logic [23:0] max_distance_q8;
   } cfg_type;

   typedef struct packed {
      logic trigger;
      logic busy_res;
      logic done_res;
      logic measured;
      status_type status;
      logic [31:0] product;
   } mid_type;

   typedef struct packed {
      logic trigger;
      logic busy_res;
      logic done_res;
      status_type status;
      logic [23:0] distance_q8;
   } res_type;

endpackage

`default_nettype wire

// ----- sv/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// path: an accepted req word reaches its rsp word through the input, mid and result registers
// throughput: one word per cycle while rsp_tready does not hold back the output
// reset: idle phase, zero tick count, registers at their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // start_req, echo
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,  // trigger, busy_res, status, distance_q8
   output logic                                 rsp_tlast,  // done_res
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_data
);
   import uer_pkg::*;

   cfg_type cfg;
   mid_type mid;
   res_type res;

   logic in_v_ff, in_v_in;
   logic mid_v_ff, mid_v_in;
   logic out_v_ff, out_v_in;
   logic start_ff, echo_ff;
   logic ready_out, ready_mid;
   logic adv_in, adv_mid, adv_out;

   assign ready_out = !out_v_ff || rsp_tready;
   assign ready_mid = !mid_v_ff || ready_out;
   assign req_tready = !in_v_ff || ready_mid;
   assign adv_in = req_tvalid && req_tready;
   assign adv_mid = in_v_ff && ready_mid;
   assign adv_out = mid_v_ff && ready_out;

   assign in_v_in = adv_in ? 1'b1 : (ready_mid ? 1'b0 : in_v_ff);
   assign mid_v_in = adv_mid ? 1'b1 : (ready_out ? 1'b0 : mid_v_ff);
   assign out_v_in = adv_out ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         start_ff <= req_tdata[0];
         echo_ff <= req_tdata[1];
      end
   end

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uer_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_mid),
      .start_req (start_ff),
      .echo      (echo_ff),
      .cfg       (cfg),
      .mid       (mid)
   );

   uer_range u_range (
      .clock   (clock),
      .advance (adv_out),
      .mid     (mid),
      .cfg     (cfg),
      .res     (res)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast = res.done_res;
   assign rsp_tdata = {4'd0, res.distance_q8, res.status, res.busy_res, res.trigger};

endmodule

`default_nettype wire

// ----- sv/uer_csr.sv -----
// ----------------------------------------------------------------------------
// uer_csr
// configuration registers of the ranger
// ----------------------------------------------------------------------------
`default_nettype none

module uer_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_data,
   output uer_pkg::cfg_type                     cfg
);
   import uer_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TRIG_WIDTH: cfg_in.trigger_width_ticks = csr_data[7:0];
            REG_ECHO_TIMEOUT: cfg_in.echo_timeout_ticks = csr_data[15:0];
            REG_SCALE: cfg_in.scale_q16 = csr_data[15:0];
            REG_MIN_DIST: cfg_in.min_distance_q8 = csr_data[23:0];
            REG_MAX_DIST: cfg_in.max_distance_q8 = csr_data[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_width_ticks <= RST_TRIG_WIDTH;
         cfg_ff.echo_timeout_ticks <= RST_ECHO_TIMEOUT;
         cfg_ff.scale_q16 <= RST_SCALE;
         cfg_ff.min_distance_q8 <= RST_MIN_DIST;
         cfg_ff.max_distance_q8 <= RST_MAX_DIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/uer_fsm.sv -----
// ----------------------------------------------------------------------------
// uer_fsm
// measurement sequencer: trigger pulse, echo wait, echo timing
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_fsm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             start_req,
   input  wire logic             echo,
   input  wire uer_pkg::cfg_type cfg,
   output uer_pkg::mid_type      mid
);
   import uer_pkg::*;

   phase_type phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   mid_type mid_ff, mid_in;
   logic meas_tick;
   logic [15:0] meas_count;

   assign mid = mid_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      meas_tick = 1'b0;
      meas_count = count_ff;
      mid_in.trigger = 1'b0;
      mid_in.done_res = 1'b0;
      mid_in.measured = 1'b0;
      mid_in.status = ST_OK;
      mid_in.product = 32'(count_ff) * 32'(cfg.scale_q16);

      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in = PH_TRIG;
               count_in = 16'd1;
               mid_in.trigger = 1'b1;
            end
         end
         PH_TRIG: begin
            if (count_ff >= 16'(cfg.trigger_width_ticks)) begin
               phase_in = PH_RISE;
               count_in = '0;
            end else begin
               mid_in.trigger = 1'b1;
               count_in = count_ff + 16'd1;
            end
         end
         PH_RISE: begin
            if (echo) begin
               meas_tick = 1'b1;
               meas_count = '0;
            end else if (count_ff >= cfg.echo_timeout_ticks) begin
               phase_in = PH_IDLE;
               count_in = '0;
               mid_in.done_res = 1'b1;
               mid_in.status = ST_NO_RISE;
            end else begin
               count_in = count_ff + 16'd1;
            end
         end
         PH_MEAS: meas_tick = 1'b1;
         default: phase_in = PH_IDLE;
      endcase

      if (meas_tick) begin
         if (echo) begin
            if (meas_count >= cfg.echo_timeout_ticks) begin
               phase_in = PH_IDLE;
               count_in = '0;
               mid_in.done_res = 1'b1;
               mid_in.status = ST_TOO_LONG;
            end else begin
               phase_in = PH_MEAS;
               count_in = meas_count + 16'd1;
            end
         end else begin
            // echo fell: count_ff holds the high time
            phase_in = PH_IDLE;
            count_in = '0;
            mid_in.done_res = 1'b1;
            mid_in.measured = 1'b1;
         end
      end

      mid_in.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   `UER_ASSERT_IMP(a_idle_count_zero, clock, reset, phase_ff == PH_IDLE, count_ff == 16'd0)
   `UER_ASSERT_IMP(a_done_not_busy, clock, reset, mid_in.done_res, !mid_in.busy_res)
   `UER_ASSERT_NXT(a_no_rise_from_wait, clock, reset,
      advance && mid_in.done_res && mid_in.status == ST_NO_RISE, $past(phase_ff) == PH_RISE)

endmodule

`default_nettype wire

// ----- sv/uer_range.sv -----
// ----------------------------------------------------------------------------
// uer_range
// rounds the scaled echo time to q8 centimetres and applies the window
// ----------------------------------------------------------------------------
`default_nettype none

module uer_range (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire uer_pkg::mid_type mid,
   input  wire uer_pkg::cfg_type cfg,
   output uer_pkg::res_type      res
);
   import uer_pkg::*;

   res_type res_ff, res_in;
   logic [32:0] rounded;
   logic [23:0] dist_q8;
   logic outside;

   assign res = res_ff;

   always_comb begin
      rounded = {1'b0, mid.product} + ROUND_HALF;
      dist_q8 = (rounded[32] != 1'b0) ? DIST_MAX : rounded[31:8];
      outside = (dist_q8 < cfg.min_distance_q8) || (dist_q8 > cfg.max_distance_q8);

      res_in.trigger = mid.trigger;
      res_in.busy_res = mid.busy_res;
      res_in.done_res = mid.done_res;
      res_in.status = mid.status;
      res_in.distance_q8 = '0;
      if (mid.measured) begin
         if (outside) begin
            res_in.status = ST_RANGE;
         end else begin
            res_in.status = ST_OK;
            res_in.distance_q8 = dist_q8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire
